// ----- hw/rtl/lredge_pkg.sv -----
// Shared types and constants for the lidar range edge detector.
// Used by lredge_isqrt and lidar_range_edge_detect; no dependencies.
`timescale 1ns / 1ps

package lredge_pkg;

   // Coordinate width in mm (two's complement), legal range 12..32
   localparam int COORD_BITS  = 20;
   // Threshold register
   localparam int THRESH_BITS = 20;
   localparam logic [THRESH_BITS-1:0] THRESH_RESET = THRESH_BITS'(50);

   // Range width (floor of the Euclidean norm always fits)
   localparam int RANGE_BITS = COORD_BITS + 1;
   // Root width of the square root unit: even, at least RANGE_BITS
   localparam int SQRT_BITS  = 2 * ((COORD_BITS + 2) / 2);
   // Radicand width: twice the root width, holds the sum of three squares
   localparam int RAD_BITS   = 2 * SQRT_BITS;
   // Compare width for the jump against the threshold
   localparam int CMP_BITS   = (RANGE_BITS > THRESH_BITS) ? RANGE_BITS : THRESH_BITS;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] point_x;
      logic signed [COORD_BITS-1:0] point_y;
      logic signed [COORD_BITS-1:0] point_z;
      logic                         ring_start;
   } req_word_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] edge_x;
      logic signed [COORD_BITS-1:0] edge_y;
      logic signed [COORD_BITS-1:0] edge_z;
   } rsp_word_type;

endpackage

// ----- hw/rtl/lidar_range_edge_detect.sv -----
// Lidar range edge detector, top level.
// Depends on lredge_pkg and lredge_isqrt.
`timescale 1ns / 1ps

// Takes one lidar point per word (signed mm x, y, z plus a ring start flag),
// computes its range as floor(sqrt(x^2 + y^2 + z^2)) and keeps a window of
// three ranges per ring. The middle point of the window is sent out when the
// larger of its range jumps to either neighbor reaches csr_wr_data's threshold
// (reset 50 mm), so results trail the input by one point and the first and last
// points of a ring never come out. A ring start flag drops the held window; the
// first point after reset opens a ring on its own. Each point goes through
// the states in order: idle takes the word, the square state runs x, y and
// z through the shared squaring multiplier and accumulator, the root state
// waits on the square root unit, which retires two root bits per cycle and
// flags done after the last ones, and the update state shifts the window;
// req_stall stays high from the square state until the update completes.
// A result waits in the output register without blocking the next point,
// unless a second result is ready before the first one is taken.
module lidar_range_edge_detect (
   input  logic                                    clock,
   input  logic                                    reset,
   // point input
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  lredge_pkg::req_word_type                req_word,
   // edge point output
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output lredge_pkg::rsp_word_type                rsp_word,
   // threshold register
   input  logic                                    csr_wr_en,
   input  logic [lredge_pkg::THRESH_BITS-1:0]      csr_wr_data
);

   localparam int CB  = lredge_pkg::COORD_BITS;
   localparam int RGB = lredge_pkg::RANGE_BITS;
   localparam int SB  = lredge_pkg::SQRT_BITS;
   localparam int RAD = lredge_pkg::RAD_BITS;
   localparam int CMP = lredge_pkg::CMP_BITS;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SQUARE = 2'd1;
   localparam logic [1:0] ST_ROOT   = 2'd2;
   localparam logic [1:0] ST_UPDATE = 2'd3;

   localparam logic [1:0] FILL_EMPTY  = 2'd0;
   localparam logic [1:0] FILL_MIDDLE = 2'd1;
   localparam logic [1:0] FILL_FULL   = 2'd2;

   logic [1:0]                       state_ff;
   logic [1:0]                       step_ff;
   lredge_pkg::req_word_type         point_ff;
   logic [2*CB-1:0]                  prod_ff;
   logic [RAD-1:0]                   acc_ff;
   logic [lredge_pkg::THRESH_BITS-1:0] thresh_ff;
   logic [RGB-1:0]                   left_ff;
   logic [RGB-1:0]                   middle_ff;
   lredge_pkg::rsp_word_type         middle_pt_ff;
   logic [1:0]                       fill_ff;
   logic                             rsp_valid_ff;
   lredge_pkg::rsp_word_type         rsp_word_ff;

   logic signed [CB-1:0]             coord_sel;
   logic [CB-1:0]                    coord_mag;
   logic [RAD-1:0]                   acc_in;
   logic                             root_start;
   logic                             root_done;
   logic [SB-1:0]                    root_val;
   logic [RGB-1:0]                   range_new;
   logic [RGB-1:0]                   diff_left;
   logic [RGB-1:0]                   diff_right;
   logic [CMP-1:0]                   diff_max;
   logic [1:0]                       fill_eff;
   logic                             hit;
   logic                             out_busy;

   // Threshold register
   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= lredge_pkg::THRESH_RESET;
      end else if (csr_wr_en) begin
         thresh_ff <= csr_wr_data;
      end
   end

   // Operand select and magnitude for the shared multiplier
   always_comb begin
      case (step_ff)
         2'd0:    coord_sel = point_ff.point_x;
         2'd1:    coord_sel = point_ff.point_y;
         default: coord_sel = point_ff.point_z;
      endcase
      coord_mag = coord_sel[CB-1] ? CB'(-coord_sel) : CB'(coord_sel);
   end

   // Accumulate the registered product
   assign acc_in     = (step_ff == 2'd0) ? '0 : acc_ff + RAD'(prod_ff);
   assign root_start = (state_ff == ST_SQUARE) && (step_ff == 2'd3);

   lredge_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (root_start),
      .radicand (acc_in),
      .done     (root_done),
      .root     (root_val)
   );

   // Window compare
   always_comb begin
      range_new  = root_val[RGB-1:0];
      diff_left  = (middle_ff >= left_ff) ? middle_ff - left_ff : left_ff - middle_ff;
      diff_right = (middle_ff >= range_new) ? middle_ff - range_new : range_new - middle_ff;
      diff_max   = (diff_left > diff_right) ? CMP'(diff_left) : CMP'(diff_right);
      fill_eff   = point_ff.ring_start ? FILL_EMPTY : fill_ff;
      hit        = (fill_eff == FILL_FULL) && (diff_max >= CMP'(thresh_ff));
      out_busy   = rsp_valid_ff && rsp_stall;
   end

   // Sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         fill_ff  <= FILL_EMPTY;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= ST_SQUARE;
                  step_ff  <= '0;
               end
            end
            ST_SQUARE: begin
               step_ff <= step_ff + 2'd1;
               if (step_ff == 2'd3) begin
                  state_ff <= ST_ROOT;
               end
            end
            ST_ROOT: begin
               if (root_done) begin
                  state_ff <= ST_UPDATE;
               end
            end
            ST_UPDATE: begin
               if (!(hit && out_busy)) begin
                  state_ff <= ST_IDLE;
                  fill_ff  <= (fill_eff == FILL_EMPTY) ? FILL_MIDDLE : FILL_FULL;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      if ((state_ff == ST_IDLE) && req_valid) begin
         point_ff <= req_word;
      end
      if (state_ff == ST_SQUARE) begin
         prod_ff <= coord_mag * coord_mag;
         acc_ff  <= acc_in;
      end
      if ((state_ff == ST_UPDATE) && !(hit && out_busy)) begin
         left_ff             <= middle_ff;
         middle_ff           <= range_new;
         middle_pt_ff.edge_x <= point_ff.point_x;
         middle_pt_ff.edge_y <= point_ff.point_y;
         middle_pt_ff.edge_z <= point_ff.point_z;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((state_ff == ST_UPDATE) && hit && !out_busy) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_UPDATE) && hit && !out_busy) begin
         rsp_word_ff <= middle_pt_ff;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

// ----- hw/rtl/lredge_isqrt.sv -----
// Iterative floor square root, two root bits per cycle.
// Depends on lredge_pkg for widths.
`timescale 1ns / 1ps

module lredge_isqrt (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [lredge_pkg::RAD_BITS-1:0]     radicand,
   output logic                                done,
   output logic [lredge_pkg::SQRT_BITS-1:0]    root
);

   localparam int RB        = lredge_pkg::RAD_BITS;
   localparam int SB        = lredge_pkg::SQRT_BITS;
   localparam int REM_BITS  = SB + 3;
   localparam int ITER      = SB / 2;
   localparam int CNT_BITS  = $clog2(ITER + 1);

   logic [RB-1:0]       rad_ff, rad_in;
   logic [REM_BITS-1:0] rem_ff, rem_in;
   logic [SB-1:0]       root_ff, root_in;
   logic [CNT_BITS-1:0] count_ff;
   logic                busy_ff;
   logic                done_ff;

   // Two restoring digit steps per cycle
   always_comb begin
      logic [REM_BITS-1:0] trial;
      rem_in  = rem_ff;
      root_in = root_ff;
      rad_in  = rad_ff;
      for (int s = 0; s < 2; s++) begin
         rem_in = {rem_in[REM_BITS-3:0], rad_in[RB-1 -: 2]};
         rad_in = {rad_in[RB-3:0], 2'b00};
         trial  = {1'b0, root_in, 2'b01};
         if (rem_in >= trial) begin
            rem_in  = rem_in - trial;
            root_in = {root_in[SB-2:0], 1'b1};
         end else begin
            root_in = {root_in[SB-2:0], 1'b0};
         end
      end
   end

   // Sequencer: load on start, iterate, pulse done
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         // done rises in the cycle after the last iteration
         done_ff <= !start && busy_ff && (count_ff == CNT_BITS'(1));
         if (start) begin
            busy_ff  <= 1'b1;
            count_ff <= CNT_BITS'(ITER);
         end else if (busy_ff) begin
            count_ff <= count_ff - CNT_BITS'(1);
            if (count_ff == CNT_BITS'(1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff  <= radicand;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         rad_ff  <= rad_in;
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule
